// ----- hdl/rpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resource pool allocator package
// Shared widths, codes, beat formats and a ring pointer helper for the allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

    // Pool and beat geometry.
    localparam int POOL_SIZE      = 16;
    localparam int REQ_WIDTH      = 8;
    localparam int WAIT_DEPTH_DEF = 16;
    localparam int ITEM_W         = $clog2(POOL_SIZE);
    localparam int POOL_CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int CFG_W          = 5;
    localparam int CFG_IDX_W      = 1;
    localparam int STATUS_W       = 3;
    localparam int STEP_W         = CFG_W - 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT = 1'b1;

    // Command codes.
    localparam logic CMD_GET     = 1'b0;
    localparam logic CMD_RECYCLE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HANDED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_KEPT    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FREED   = 3'd5;

    // Input beat.
    typedef struct packed {
        logic                 command;
        logic [REQ_WIDTH-1:0] requester_id;
        logic [ITEM_W-1:0]    item_index;
    } rpa_cmd_t;

    // Output beat.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ITEM_W-1:0]    granted_item;
        logic [REQ_WIDTH-1:0] granted_requester;
    } rpa_rsp_t;

    // Configuration register file.
    typedef struct packed {
        logic [CFG_W-1:0] keep_count;
        logic [CFG_W-1:0] wait_limit;
    } rpa_cfg_t;

    // Access request to one of the item-index rings.
    typedef struct packed {
        logic              re;
        logic [ITEM_W-1:0] raddr;
        logic              we;
        logic [ITEM_W-1:0] waddr;
        logic [ITEM_W-1:0] wdata;
    } rpa_pool_port_t;

    // Advance a pointer of an item-index ring with wraparound.
    function automatic logic [ITEM_W-1:0] next_pool(input logic [ITEM_W-1:0] p);
        next_pool = (p == ITEM_W'(POOL_SIZE - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ----- hdl/rpa_ring_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring storage RAM
// One write port and one registered read port. With INIT_ADDR set, an entry
// that was never written since reset reads back as its own address.
// ----------------------------------------------------------------------------
module rpa_ring_ram #(
    parameter int DEPTH     = 16,
    parameter int WIDTH     = 4,
    parameter int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter bit INIT_ADDR = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    generate
        if (INIT_ADDR)
        begin : g_init
            logic [DEPTH-1:0] written_reg;

            // One written flag per entry, cleared by reset.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    written_reg <= '0;
                end
                else if (we)
                begin
                    written_reg[waddr] <= 1'b1;
                end
            end

            // Registered read; an unwritten entry returns its address.
            always_ff @(posedge clk)
            begin
                if (re)
                begin
                    rdata_reg <= written_reg[raddr] ? mem[raddr] : WIDTH'(raddr);
                end
            end
        end
        else
        begin : g_plain
            // Registered read.
            always_ff @(posedge clk)
            begin
                if (re)
                begin
                    rdata_reg <= mem[raddr];
                end
            end
        end
    endgenerate

    assign rdata = rdata_reg;

endmodule

// ----- hdl/rpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator sequencer
// Holds the ring pointers and counts, steps through each command and drives
// the ring RAMs, and keeps the output beat register.
// ----------------------------------------------------------------------------
module rpa_ctrl
    import rpa_pkg::*;
#(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
    parameter int WAIT_AW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rpa_cfg_t             cfg,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  rpa_cmd_t             cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rpa_rsp_t             rsp,
    output rpa_pool_port_t       free_port,
    input  logic [ITEM_W-1:0]    free_rdata,
    output rpa_pool_port_t       idle_port,
    input  logic [ITEM_W-1:0]    idle_rdata,
    output logic                 wait_we,
    output logic [WAIT_AW-1:0]   wait_waddr,
    output logic [REQ_WIDTH-1:0] wait_wdata,
    output logic                 wait_re,
    output logic [WAIT_AW-1:0]   wait_raddr,
    input  logic [REQ_WIDTH-1:0] wait_rdata
);

    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int CAP_W  = (WCNT_W > CFG_W) ? WCNT_W : CFG_W;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECIDE    = 3'd1;
    localparam logic [2:0] S_REFILL    = 3'd2;
    localparam logic [2:0] S_REFILL_WR = 3'd3;
    localparam logic [2:0] S_RESULT    = 3'd4;

    logic [2:0]            state_reg, state_next;
    rpa_cmd_t              cmd_reg, cmd_next;
    logic                  refilled_reg, refilled_next;
    logic [STEP_W-1:0]     moved_reg, moved_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [ITEM_W-1:0]     free_head_reg, free_head_next;
    logic [ITEM_W-1:0]     free_tail_reg, free_tail_next;
    logic [POOL_CNT_W-1:0] free_count_reg, free_count_next;
    logic [ITEM_W-1:0]     idle_head_reg, idle_head_next;
    logic [ITEM_W-1:0]     idle_tail_reg, idle_tail_next;
    logic [POOL_CNT_W-1:0] idle_count_reg, idle_count_next;
    logic [WAIT_AW-1:0]    wait_head_reg, wait_head_next;
    logic [WAIT_AW-1:0]    wait_tail_reg, wait_tail_next;
    logic [WCNT_W-1:0]     wait_count_reg, wait_count_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rpa_rsp_t              rsp_reg, rsp_next;

    logic [STEP_W-1:0]     step;
    logic [CAP_W-1:0]      wait_cap;
    logic                  wait_full;
    logic                  idle_room;
    rpa_rsp_t              result;

    function automatic logic [WAIT_AW-1:0] next_wait(input logic [WAIT_AW-1:0] p);
        next_wait = (p == WAIT_AW'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Refill batch size, at least one index.
    always_comb
    begin
        step = cfg.keep_count[CFG_W-1:1];
        if (step == '0)
        begin
            step = STEP_W'(1);
        end
    end

    // Wait ring capacity is the smaller of the limit and the ring depth.
    assign wait_cap  = (CAP_W'(cfg.wait_limit) < CAP_W'(WAIT_DEPTH)) ?
                       CAP_W'(cfg.wait_limit) : CAP_W'(WAIT_DEPTH);
    assign wait_full = (CAP_W'(wait_count_reg) >= wait_cap);
    assign idle_room = (idle_count_reg < cfg.keep_count) &&
                       (idle_count_reg < POOL_CNT_W'(POOL_SIZE));

    // Result beat assembled from the decision and any ring read data.
    always_comb
    begin
        result.status            = res_status_reg;
        result.granted_item      = '0;
        result.granted_requester = '0;
        case (res_status_reg) inside
            ST_GRANTED:
            begin
                result.granted_item      = idle_rdata;
                result.granted_requester = cmd_reg.requester_id;
            end
            ST_HANDED:
            begin
                result.granted_item      = cmd_reg.item_index;
                result.granted_requester = wait_rdata;
            end
            ST_KEPT, ST_FREED:
            begin
                result.granted_item = cmd_reg.item_index;
            end
            default:
            begin
                result.granted_item = '0;
            end
        endcase
    end

    // Command sequencer.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        refilled_next   = refilled_reg;
        moved_next      = moved_reg;
        res_status_next = res_status_reg;
        free_head_next  = free_head_reg;
        free_tail_next  = free_tail_reg;
        free_count_next = free_count_reg;
        idle_head_next  = idle_head_reg;
        idle_tail_next  = idle_tail_reg;
        idle_count_next = idle_count_reg;
        wait_head_next  = wait_head_reg;
        wait_tail_next  = wait_tail_reg;
        wait_count_next = wait_count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        free_port       = '0;
        idle_port       = '0;
        wait_we         = 1'b0;
        wait_waddr      = wait_tail_reg;
        wait_wdata      = cmd_reg.requester_id;
        wait_re         = 1'b0;
        wait_raddr      = wait_head_reg;
        cmd_ready       = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next      = cmd;
                    refilled_next = 1'b0;
                    state_next    = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = S_RESULT;
                if (cmd_reg.command == CMD_GET)
                begin
                    if ((idle_count_reg == '0) && !refilled_reg)
                    begin
                        moved_next = '0;
                        state_next = S_REFILL;
                    end
                    else if (idle_count_reg != '0)
                    begin
                        idle_port.re    = 1'b1;
                        idle_port.raddr = idle_head_reg;
                        idle_head_next  = next_pool(idle_head_reg);
                        idle_count_next = idle_count_reg - 1'b1;
                        res_status_next = ST_GRANTED;
                    end
                    else if (wait_full)
                    begin
                        res_status_next = ST_REFUSED;
                    end
                    else
                    begin
                        wait_we         = 1'b1;
                        wait_tail_next  = next_wait(wait_tail_reg);
                        wait_count_next = wait_count_reg + 1'b1;
                        res_status_next = ST_QUEUED;
                    end
                end
                else
                begin
                    if (wait_count_reg != '0)
                    begin
                        wait_re         = 1'b1;
                        wait_head_next  = next_wait(wait_head_reg);
                        wait_count_next = wait_count_reg - 1'b1;
                        res_status_next = ST_HANDED;
                    end
                    else if (idle_room)
                    begin
                        idle_port.we    = 1'b1;
                        idle_port.waddr = idle_tail_reg;
                        idle_port.wdata = cmd_reg.item_index;
                        idle_tail_next  = next_pool(idle_tail_reg);
                        idle_count_next = idle_count_reg + 1'b1;
                        res_status_next = ST_KEPT;
                    end
                    else
                    begin
                        // A full free ring drops the index.
                        if (free_count_reg < POOL_CNT_W'(POOL_SIZE))
                        begin
                            free_port.we    = 1'b1;
                            free_port.waddr = free_tail_reg;
                            free_port.wdata = cmd_reg.item_index;
                            free_tail_next  = next_pool(free_tail_reg);
                            free_count_next = free_count_reg + 1'b1;
                        end
                        res_status_next = ST_FREED;
                    end
                end
            end

            S_REFILL:
            begin
                if ((moved_reg < step) && (free_count_reg != '0) &&
                    (idle_count_reg < POOL_CNT_W'(POOL_SIZE)))
                begin
                    free_port.re    = 1'b1;
                    free_port.raddr = free_head_reg;
                    free_head_next  = next_pool(free_head_reg);
                    free_count_next = free_count_reg - 1'b1;
                    state_next      = S_REFILL_WR;
                end
                else
                begin
                    refilled_next = 1'b1;
                    state_next    = S_DECIDE;
                end
            end

            S_REFILL_WR:
            begin
                idle_port.we    = 1'b1;
                idle_port.waddr = idle_tail_reg;
                idle_port.wdata = free_rdata;
                idle_tail_next  = next_pool(idle_tail_reg);
                idle_count_next = idle_count_reg + 1'b1;
                moved_next      = moved_reg + 1'b1;
                state_next      = S_REFILL;
            end

            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = result;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            refilled_reg   <= 1'b0;
            moved_reg      <= '0;
            free_head_reg  <= '0;
            free_tail_reg  <= '0;
            free_count_reg <= POOL_CNT_W'(POOL_SIZE);
            idle_head_reg  <= '0;
            idle_tail_reg  <= '0;
            idle_count_reg <= '0;
            wait_head_reg  <= '0;
            wait_tail_reg  <= '0;
            wait_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            refilled_reg   <= refilled_next;
            moved_reg      <= moved_next;
            free_head_reg  <= free_head_next;
            free_tail_reg  <= free_tail_next;
            free_count_reg <= free_count_next;
            idle_head_reg  <= idle_head_next;
            idle_tail_reg  <= idle_tail_next;
            idle_count_reg <= idle_count_next;
            wait_head_reg  <= wait_head_next;
            wait_tail_reg  <= wait_tail_next;
            wait_count_reg <= wait_count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- hdl/resource_pool_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resource pool allocator
// Hands out item indices from a free ring through an idle ring, queues
// requesters when none are left, and routes recycled indices back.
// ----------------------------------------------------------------------------
// Commands are handled one at a time by a sequencer that reads, modifies and
// writes three ring RAMs (free, idle, waiting requesters), each with a
// registered read. A recycle, or a get that finds the idle ring non-empty,
// steps through a decide state and a result state that registers its result
// beat, then returns to idle, and only there can the next command be
// accepted. A new command is accepted even if the previous result has not
// been taken yet; it then waits in its last step until the output register
// frees up. A get that finds the idle ring empty first moves indices from the
// free ring, each by a free read step and an idle write step, and then decides
// again and registers its result. It moves at most max(1, keep_count/2)
// indices, and may move none when the free ring is empty. The free ring
// starts full of indices 0 to POOL_SIZE-1 at reset without any clearing
// pass. Configuration writes are always accepted and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module resource_pool_allocator
    import rpa_pkg::*;
#(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  rpa_cmd_t             cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rpa_rsp_t             rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int WAIT_AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

    rpa_cfg_t             cfg_reg, cfg_next;
    rpa_pool_port_t       free_port;
    rpa_pool_port_t       idle_port;
    logic [ITEM_W-1:0]    free_rdata;
    logic [ITEM_W-1:0]    idle_rdata;
    logic                 wait_we;
    logic [WAIT_AW-1:0]   wait_waddr;
    logic [REQ_WIDTH-1:0] wait_wdata;
    logic                 wait_re;
    logic [WAIT_AW-1:0]   wait_raddr;
    logic [REQ_WIDTH-1:0] wait_rdata;

    // Configuration register write decode.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEEP_COUNT: cfg_next.keep_count = cfg_data;
                CFG_WAIT_LIMIT: cfg_next.wait_limit = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keep_count <= CFG_W'(4);
            cfg_reg.wait_limit <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer.
    rpa_ctrl #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .WAIT_AW    (WAIT_AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .free_port  (free_port),
        .free_rdata (free_rdata),
        .idle_port  (idle_port),
        .idle_rdata (idle_rdata),
        .wait_we    (wait_we),
        .wait_waddr (wait_waddr),
        .wait_wdata (wait_wdata),
        .wait_re    (wait_re),
        .wait_raddr (wait_raddr),
        .wait_rdata (wait_rdata)
    );

    // Free ring, preloaded with every index in order.
    rpa_ring_ram #(
        .DEPTH     (POOL_SIZE),
        .WIDTH     (ITEM_W),
        .ADDR_W    (ITEM_W),
        .INIT_ADDR (1'b1)
    ) u_free_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (free_port.we),
        .waddr (free_port.waddr),
        .wdata (free_port.wdata),
        .re    (free_port.re),
        .raddr (free_port.raddr),
        .rdata (free_rdata)
    );

    // Idle ring.
    rpa_ring_ram #(
        .DEPTH     (POOL_SIZE),
        .WIDTH     (ITEM_W),
        .ADDR_W    (ITEM_W),
        .INIT_ADDR (1'b0)
    ) u_idle_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (idle_port.we),
        .waddr (idle_port.waddr),
        .wdata (idle_port.wdata),
        .re    (idle_port.re),
        .raddr (idle_port.raddr),
        .rdata (idle_rdata)
    );

    // Waiting requester ring.
    rpa_ring_ram #(
        .DEPTH     (WAIT_DEPTH),
        .WIDTH     (REQ_WIDTH),
        .ADDR_W    (WAIT_AW),
        .INIT_ADDR (1'b0)
    ) u_wait_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (wait_we),
        .waddr (wait_waddr),
        .wdata (wait_wdata),
        .re    (wait_re),
        .raddr (wait_raddr),
        .rdata (wait_rdata)
    );

endmodule
